/* rtl/absolute_path_redactor_defines.svh */
// ----------------------------------------------------------------------------
// Absolute path redactor assertion macros
// Concurrent assertion shorthands used by the redactor top level.
// ----------------------------------------------------------------------------
`ifndef ABSOLUTE_PATH_REDACTOR_DEFINES_SVH
`define ABSOLUTE_PATH_REDACTOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define APR_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define APR_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/apr_pkg.sv */
// ----------------------------------------------------------------------------
// Absolute path redactor package
// Character classes, token text, decision function and queue command types.
// ----------------------------------------------------------------------------
`default_nettype none

package apr_pkg;

  localparam int unsigned TOKEN_LEN      = 15;
  localparam int unsigned FIFO_DEPTH_DEF = 4;

  localparam logic [8*TOKEN_LEN-1:0] TOKEN_TEXT = {"[REDACTED", "_PATH]"};

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;

  typedef enum logic [1:0] {
    SLOT_NONE  = 2'd0,
    SLOT_BYTE  = 2'd1,
    SLOT_TOKEN = 2'd2
  } slot_kind_t;

  typedef struct packed {
    slot_kind_t kind;
    logic [7:0] data;
  } slot_t;

  // One queued request: up to three compacted output slots.
  typedef struct packed {
    slot_t [2:0] slots;
    logic  [1:0] n_slots;
    logic        last;
  } cmd_t;

  typedef struct packed {
    slot_t      slot;
    logic       drive;
    logic [7:0] prev;
    logic       skip;
  } dec_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c inside {[CH_TAB:CH_CR]});
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c inside {[CH_UPPER_A:CH_UPPER_Z], [CH_LOWER_A:CH_LOWER_Z]});
  endfunction

  function automatic logic is_slash(input logic [7:0] c);
    return (c inside {CH_SLASH, CH_BSLASH});
  endfunction

  function automatic logic is_boundary(input logic [7:0] c);
    return is_space(c) || (c inside {CH_EQUAL, CH_DQUOTE, CH_SQUOTE, CH_LPAREN, CH_LBRACK});
  endfunction

  function automatic logic ends_path(input logic [7:0] c);
    return is_space(c) || (c inside {CH_DQUOTE, CH_SQUOTE, CH_RPAREN, CH_RBRACK});
  endfunction

  function automatic logic [7:0] token_char(input logic [3:0] idx);
    return TOKEN_TEXT[(TOKEN_LEN - 1 - int'(idx)) * 8 +: 8];
  endfunction

  // Decide the byte at w0; full3 says w1 and w2 are known.
  function automatic dec_t decide(input logic [7:0] w0, input logic [7:0] w1,
                                  input logic [7:0] w2, input logic full3,
                                  input logic [7:0] prev, input logic start,
                                  input logic skip);
    dec_t d;
    d.slot.kind = SLOT_NONE;
    d.slot.data = w0;
    d.drive     = 1'b0;
    d.prev      = w0;
    d.skip      = skip;
    if (skip) begin
      if (ends_path(w0)) begin
        d.skip      = 1'b0;
        d.slot.kind = SLOT_BYTE;
      end
    end else if (full3 && is_alpha(w0) && (w1 == CH_COLON) && is_slash(w2)) begin
      d.slot.kind = SLOT_TOKEN;
      d.skip      = 1'b1;
      d.drive     = 1'b1;
      d.prev      = w2;
    end else if ((start || is_boundary(prev)) && is_slash(w0)) begin
      d.slot.kind = SLOT_TOKEN;
      d.skip      = 1'b1;
    end else begin
      d.slot.kind = SLOT_BYTE;
    end
    return d;
  endfunction

endpackage

`default_nettype wire

/* rtl/apr_if.sv */
// ----------------------------------------------------------------------------
// Absolute path redactor channels
// Valid/ready interfaces for the text input and the redacted output.
// ----------------------------------------------------------------------------
`default_nettype none

interface apr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface apr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       carries_byte;
  logic       end_of_output;

  modport source (output valid, output out_byte, output carries_byte,
                  output end_of_output, input ready);
  modport sink   (input valid, input out_byte, input carries_byte,
                  input end_of_output, output ready);
endinterface

`default_nettype wire

/* rtl/apr_fifo.sv */
// ----------------------------------------------------------------------------
// Redactor command queue
// Small register FIFO between the classifier and the output sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module apr_fifo #(
  parameter int unsigned DEPTH = apr_pkg::FIFO_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  apr_pkg::cmd_t push_data,
  output logic          full,
  input  logic          pop,
  output apr_pkg::cmd_t pop_data,
  output logic          empty
);
  import apr_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  cmd_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

/* rtl/apr_front.sv */
// ----------------------------------------------------------------------------
// Redactor classifier
// Hold two bytes of lookahead, decide each byte and queue output requests.
// ----------------------------------------------------------------------------
`default_nettype none

module apr_front (
  input  logic          clk,
  input  logic          rst_n,
  apr_in_if.sink        in_chan,
  output logic          push,
  output apr_pkg::cmd_t push_data,
  input  logic          full
);
  import apr_pkg::*;

  logic [7:0] la0_r, la0_nxt;
  logic [7:0] la1_r, la1_nxt;
  logic [1:0] la_cnt_r, la_cnt_nxt;
  logic [7:0] prev_r, prev_nxt;
  logic       start_r, start_nxt;
  logic       skip_r, skip_nxt;

  logic [7:0]  w0, w1, w2;
  logic        accept;
  dec_t        d0, d1, d2;
  slot_t [2:0] raw;
  cmd_t        cmd;
  logic [1:0]  n;

  assign in_chan.ready = !full;
  assign accept        = in_chan.valid && !full;

  // Window: waiting bytes first, new byte behind them.
  always_comb begin
    w0 = in_chan.text_byte;
    w1 = 8'h00;
    w2 = 8'h00;
    case (la_cnt_r)
      2'd1: begin
        w0 = la0_r;
        w1 = in_chan.text_byte;
      end
      2'd2: begin
        w0 = la0_r;
        w1 = la1_r;
        w2 = in_chan.text_byte;
      end
      default: ;
    endcase
  end

  // Decisions chain; later ones matter only when flushing a string.
  assign d0 = decide(w0, w1, w2, la_cnt_r == 2'd2, prev_r, start_r, skip_r);
  assign d1 = decide(w1, w2, 8'h00, 1'b0, d0.prev, 1'b0, d0.skip);
  assign d2 = decide(w2, 8'h00, 8'h00, 1'b0, d1.prev, 1'b0, d1.skip);

  always_comb begin
    raw[0] = d0.slot;
    raw[1] = '0;
    raw[2] = '0;
    if (in_chan.end_of_text && !d0.drive) begin
      if (la_cnt_r != 2'd0) raw[1] = d1.slot;
      if (la_cnt_r == 2'd2) raw[2] = d2.slot;
    end
    // Compact: occupied slots first.
    cmd = '0;
    n   = 2'd0;
    for (int i = 0; i < 3; i++) begin
      if (raw[i].kind != SLOT_NONE) begin
        cmd.slots[n] = raw[i];
        n = n + 2'd1;
      end
    end
    cmd.n_slots = n;
    cmd.last    = in_chan.end_of_text;
  end

  assign push_data = cmd;

  always_comb begin
    push       = 1'b0;
    la0_nxt    = la0_r;
    la1_nxt    = la1_r;
    la_cnt_nxt = la_cnt_r;
    prev_nxt   = prev_r;
    start_nxt  = start_r;
    skip_nxt   = skip_r;
    if (accept) begin
      if (in_chan.end_of_text) begin
        push       = 1'b1;
        la_cnt_nxt = 2'd0;
        prev_nxt   = 8'h00;
        start_nxt  = 1'b1;
        skip_nxt   = 1'b0;
      end else if (la_cnt_r == 2'd2) begin
        push      = (d0.slot.kind != SLOT_NONE);
        prev_nxt  = d0.prev;
        start_nxt = 1'b0;
        skip_nxt  = d0.skip;
        if (d0.drive) begin
          la_cnt_nxt = 2'd0;
        end else begin
          la0_nxt = w1;
          la1_nxt = w2;
        end
      end else begin
        if (la_cnt_r == 2'd0) la0_nxt = in_chan.text_byte;
        else                  la1_nxt = in_chan.text_byte;
        la_cnt_nxt = la_cnt_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      la_cnt_r <= 2'd0;
      prev_r   <= 8'h00;
      start_r  <= 1'b1;
      skip_r   <= 1'b0;
    end else begin
      la_cnt_r <= la_cnt_nxt;
      prev_r   <= prev_nxt;
      start_r  <= start_nxt;
      skip_r   <= skip_nxt;
    end
  end

  always_ff @(posedge clk) begin
    la0_r <= la0_nxt;
    la1_r <= la1_nxt;
  end

endmodule

`default_nettype wire

/* rtl/apr_back.sv */
// ----------------------------------------------------------------------------
// Redactor output sequencer
// Expand queued requests into output bytes, one per cycle while the output is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module apr_back (
  input  logic          clk,
  input  logic          rst_n,
  output logic          pop,
  input  apr_pkg::cmd_t pop_data,
  input  logic          empty,
  apr_out_if.source     out_chan
);
  import apr_pkg::*;

  logic       busy_r, busy_nxt;
  cmd_t       cmd_r, cmd_nxt;
  logic [1:0] slot_idx_r, slot_idx_nxt;
  logic [3:0] tok_idx_r, tok_idx_nxt;

  slot_t cur;
  logic  bare, tok_end, slot_done, final_slot, cmd_done, fire;

  assign cur        = cmd_r.slots[slot_idx_r];
  assign bare       = (cmd_r.n_slots == 2'd0);
  assign tok_end    = (tok_idx_r == 4'(TOKEN_LEN - 1));
  assign slot_done  = bare || (cur.kind == SLOT_BYTE) || tok_end;
  assign final_slot = bare || (slot_idx_r == cmd_r.n_slots - 2'd1);
  assign cmd_done   = slot_done && final_slot;
  assign fire       = busy_r && out_chan.ready;

  assign out_chan.valid         = busy_r;
  assign out_chan.carries_byte  = !bare;
  assign out_chan.end_of_output = cmd_r.last && cmd_done;
  assign out_chan.out_byte      = bare ? 8'h00 :
                                  (cur.kind == SLOT_TOKEN) ? token_char(tok_idx_r) : cur.data;

  assign pop = !empty && (!busy_r || (fire && cmd_done));

  always_comb begin
    busy_nxt     = busy_r;
    cmd_nxt      = cmd_r;
    slot_idx_nxt = slot_idx_r;
    tok_idx_nxt  = tok_idx_r;
    if (pop) begin
      busy_nxt     = 1'b1;
      cmd_nxt      = pop_data;
      slot_idx_nxt = 2'd0;
      tok_idx_nxt  = 4'd0;
    end else if (fire && cmd_done) begin
      busy_nxt = 1'b0;
    end else if (fire) begin
      if (slot_done) begin
        slot_idx_nxt = slot_idx_r + 2'd1;
        tok_idx_nxt  = 4'd0;
      end else begin
        tok_idx_nxt = tok_idx_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b0;
      slot_idx_r <= 2'd0;
      tok_idx_r  <= 4'd0;
    end else begin
      busy_r     <= busy_nxt;
      slot_idx_r <= slot_idx_nxt;
      tok_idx_r  <= tok_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
  end

endmodule

`default_nettype wire

/* rtl/absolute_path_redactor.sv */
// ----------------------------------------------------------------------------
// Absolute path redactor
// Replace absolute POSIX and drive paths in a byte stream with a fixed token.
// ----------------------------------------------------------------------------
//
//   channel   dir  payload                                     handshake
//   in_chan   in   text_byte[7:0], end_of_text                 valid/ready
//   out_chan  out  out_byte[7:0], carries_byte, end_of_output  valid/ready
//
// Input takes one byte per cycle whenever the request queue has room.
// Output gives one result per cycle while out_chan is ready; a redacted path expands into the full token.
// Output trails input by up to two bytes of lookahead, and each request passes
// through the queue into the output register.
// Reset is synchronous; no memory clearing pass.
// Either side may stall: the queue of FIFO_DEPTH requests absorbs the slack.
//
`default_nettype none

`include "absolute_path_redactor_defines.svh"

module absolute_path_redactor #(
  parameter int unsigned FIFO_DEPTH = apr_pkg::FIFO_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  apr_in_if.sink    in_chan,
  apr_out_if.source out_chan
);
  import apr_pkg::*;

  logic push, full, pop, empty;
  cmd_t push_data, pop_data;

  // Front: hold lookahead, classify, queue byte and token requests.
  apr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .push      (push),
    .push_data (push_data),
    .full      (full)
  );

  // Queue: decouple classification from output backpressure.
  apr_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

  // Back: expand each request into output bytes.
  apr_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .pop      (pop),
    .pop_data (pop_data),
    .empty    (empty),
    .out_chan (out_chan)
  );

  // Never push into a full queue.
  `APR_ASSERT_NOW(a_no_overflow, clk, rst_n, push, !full, "push into full queue")
  // A bare marker is always the final result of a string.
  `APR_ASSERT_NOW(a_bare_is_final, clk, rst_n, out_chan.valid && !out_chan.carries_byte, out_chan.end_of_output, "bare marker not final")
  // The final byte of a string always leaves a request behind.
  `APR_ASSERT_NEXT(a_last_queued, clk, rst_n, in_chan.valid && in_chan.ready && in_chan.end_of_text, !empty, "final byte not queued")

endmodule

`default_nettype wire

/* tb/sv/tb_top.sv */
// ----------------------------------------------------------------------------
// Absolute path redactor testbench
// Streams strings into the redactor through the valid/ready input channel and
// checks every result against a bit-accurate predictor or typed expected text:
// a directed table of edge cases first, then random strings rich in path
// fragments, under three idling patterns on the two channels.
// ----------------------------------------------------------------------------
module tb_top;

  // One result of the redacted stream.
  typedef struct packed {
    logic [7:0] text;
    logic       carries;
    logic       eot;
  } redacted_t;

  // How a directed request is checked: by the predictor, against typed text,
  // or as a bare end marker.
  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_TEXT,
    CHK_END_MARK
  } row_check_t;

  typedef struct {
    logic [7:0] b;
    bit         last;
    row_check_t how;
    string      want;
  } dir_row_t;

  localparam int NO_ROW      = -1;
  localparam int TOKEN_BYTES = 15;
  localparam int PHASE_ITEMS = 112;
  localparam int DRAIN_WAIT  = 20;
  localparam int RUN_LIMIT   = 2000000;
  localparam logic [8*TOKEN_BYTES-1:0] REDACT_TOKEN = {"[REDACTED", "_PATH]"};
  localparam string TOKEN_STR = {"[REDACTED", "_PATH]"};

  // Directed requests; each string ends on the row with last set.
  localparam int DIR_ROWS = 26;
  dir_row_t directed_rows [DIR_ROWS] = '{
    // slash at string start, string ends inside the path
    '{"/",   1'b0, CHK_TEXT,  ""},
    '{"x",   1'b1, CHK_TEXT,  TOKEN_STR},
    // drive prefix cut short by the end of the string
    '{"C",   1'b0, CHK_TEXT,  ""},
    '{":",   1'b1, CHK_TEXT,  "C:"},
    // byte extremes
    '{8'h00, 1'b0, CHK_MODEL, ""},
    '{8'hFF, 1'b1, CHK_MODEL, ""},
    // drive path closed by a paren
    '{"z",   1'b0, CHK_TEXT,  ""},
    '{":",   1'b0, CHK_TEXT,  ""},
    '{"\\",  1'b0, CHK_TEXT,  TOKEN_STR},
    '{"q",   1'b0, CHK_TEXT,  ""},
    '{")",   1'b1, CHK_TEXT,  ")"},
    // string ends while dropping: nothing left, bare end marker
    '{"/",   1'b0, CHK_TEXT,  ""},
    '{"a",   1'b0, CHK_TEXT,  ""},
    '{"b",   1'b0, CHK_TEXT,  TOKEN_STR},
    '{"c",   1'b0, CHK_TEXT,  ""},
    '{"d",   1'b1, CHK_END_MARK, ""},
    // slash after a letter passes, slash after an open paren redacts
    '{"a",   1'b0, CHK_MODEL, ""},
    '{"/",   1'b0, CHK_MODEL, ""},
    '{"b",   1'b0, CHK_MODEL, ""},
    '{"(",   1'b0, CHK_MODEL, ""},
    '{"/",   1'b0, CHK_MODEL, ""},
    '{"c",   1'b1, CHK_MODEL, ""},
    // single-byte string
    '{"/",   1'b1, CHK_TEXT,  TOKEN_STR},
    // equals boundary, path closed by a single quote
    '{"=",   1'b0, CHK_MODEL, ""},
    '{"/",   1'b0, CHK_MODEL, ""},
    '{"'",   1'b1, CHK_MODEL, ""}
  };

  logic clk;
  logic rst_n;

  apr_in_if  in_chan ();
  apr_out_if out_chan ();

  absolute_path_redactor dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always #1 clk = ~clk;

  // Idle rates in percent; the main sequence changes them per phase.
  int send_idle_pct = 21;
  int recv_idle_pct = 85;
  int mismatches    = 0;

  // Directed row carried by the request on the bus, NO_ROW for random text.
  int item_row;

  // Expected redacted stream, oldest first.
  redacted_t awaited_out [$];
  // Results of the current request, as the predictor works them out.
  redacted_t model_out [$];

  // Predictor state: bytes still waiting for a decision and per-string context.
  logic [7:0] held_bytes [2];
  int         held_cnt;
  logic [7:0] prior_byte;
  bit         fresh_string;
  bit         in_path;

  function automatic void add_model(input redacted_t r);
    model_out.insert(model_out.size(), r);
  endfunction

  function automatic void add_awaited(input redacted_t r);
    awaited_out.insert(awaited_out.size(), r);
  endfunction

  function automatic bit is_blank(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic bit is_sep(input logic [7:0] c);
    return c == "/" || c == "\\";
  endfunction

  function automatic bit is_letter(input logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic void clear_string_state();
    held_bytes   = '{8'h00, 8'h00};
    held_cnt     = 0;
    prior_byte   = 8'h00;
    fresh_string = 1'b1;
    in_path      = 1'b0;
  endfunction

  function automatic void push_token();
    for (int i = 0; i < TOKEN_BYTES; i++)
      add_model('{REDACT_TOKEN[(TOKEN_BYTES-1-i)*8 +: 8], 1'b1, 1'b0});
  endfunction

  // Decide the byte at w0 with avail bytes known; return how many it consumes.
  function automatic int decide_next(input logic [7:0] w0, input logic [7:0] w1,
                                     input logic [7:0] w2, input int avail);
    if (in_path) begin
      // Drop path bytes until a closing byte, which passes as text.
      if (is_blank(w0) || w0 == "\"" || w0 == "'" || w0 == ")" || w0 == "]") begin
        in_path = 1'b0;
        add_model('{w0, 1'b1, 1'b0});
      end
      prior_byte   = w0;
      fresh_string = 1'b0;
      return 1;
    end
    if (avail >= 3 && is_letter(w0) && w1 == ":" && is_sep(w2)) begin
      push_token();
      in_path      = 1'b1;
      prior_byte   = w2;
      fresh_string = 1'b0;
      return 3;
    end
    if ((fresh_string || is_blank(prior_byte) || prior_byte == "=" || prior_byte == "\"" ||
         prior_byte == "'" || prior_byte == "(" || prior_byte == "[") && is_sep(w0)) begin
      push_token();
      in_path = 1'b1;
    end else begin
      add_model('{w0, 1'b1, 1'b0});
    end
    prior_byte   = w0;
    fresh_string = 1'b0;
    return 1;
  endfunction

  // Advance the predictor by one request; results land in model_out.
  function automatic void redact_step(input logic [7:0] b, input bit last);
    logic [7:0] win [5];
    int         len;
    int         pos;
    int         used;
    model_out.delete();
    win = '{default: 8'h00};
    for (int i = 0; i < held_cnt; i++)
      win[i] = held_bytes[i];
    win[held_cnt] = b;
    len = held_cnt + 1;
    if (!last) begin
      // Hold bytes until a full three-byte window allows a decision.
      if (len == 3) begin
        used = decide_next(win[0], win[1], win[2], 3);
        for (int i = 0; i < 3 - used; i++)
          held_bytes[i] = win[used + i];
        held_cnt = 3 - used;
      end else begin
        for (int i = 0; i < len; i++)
          held_bytes[i] = win[i];
        held_cnt = len;
      end
      return;
    end
    // Flush every pending byte at the end of the string.
    pos = 0;
    while (pos < len)
      pos += decide_next(win[pos], win[pos + 1], win[pos + 2], len - pos);
    if (model_out.size() == 0)
      add_model('{8'h00, 1'b0, 1'b1});
    else
      model_out[$].eot = 1'b1;
    clear_string_state();
  endfunction

  initial clear_string_state();

  // Check each accepted result, then predict from each accepted request.
  // Both happen here so their order within a step is fixed.
  always @(posedge clk) begin : score
    redacted_t got;
    redacted_t want;
    dir_row_t  row;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      got = '{out_chan.out_byte, out_chan.carries_byte, out_chan.end_of_output};
      if (awaited_out.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h/%b/%b",
                 $time, got.text, got.carries, got.eot);
        mismatches++;
      end else begin
        want = awaited_out.pop_front();
        if (got.text !== want.text) begin
          $display("%0t: out_byte expected %h actual %h", $time, want.text, got.text);
          mismatches++;
        end
        if (got.carries !== want.carries) begin
          $display("%0t: carries_byte expected %b actual %b", $time, want.carries,
                   got.carries);
          mismatches++;
        end
        if (got.eot !== want.eot) begin
          $display("%0t: end_of_output expected %b actual %b", $time, want.eot, got.eot);
          mismatches++;
        end
      end
    end
    if (rst_n && in_chan.valid && in_chan.ready) begin
      redact_step(in_chan.text_byte, in_chan.end_of_text);
      if (item_row == NO_ROW || directed_rows[item_row].how == CHK_MODEL) begin
        foreach (model_out[i])
          add_awaited(model_out[i]);
      end else begin
        // Typed rows replace the prediction; the predictor still advances.
        row = directed_rows[item_row];
        if (row.how == CHK_END_MARK)
          add_awaited('{8'h00, 1'b0, 1'b1});
        else
          for (int i = 0; i < row.want.len(); i++)
            add_awaited('{row.want[i], 1'b1, row.last && i == row.want.len() - 1});
      end
    end
    // Stall the result channel at the current rate.
    out_chan.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Offer one request; return at the edge that accepts it.
  task automatic send_item(input logic [7:0] b, input bit last, input int row);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid       <= 1'b1;
    in_chan.text_byte   <= b;
    in_chan.end_of_text <= last;
    item_row            <= row;
    do
      @(posedge clk);
    while (!in_chan.ready);
  endtask

  function automatic logic [7:0] random_letter();
    // Upper or lower case ASCII letter.
    return $urandom_range(0, 1) ? 8'($urandom_range(65, 90)) : 8'($urandom_range(97, 122));
  endfunction

  initial begin : stimulus
    logic [7:0] text_q [$];
    logic [7:0] openers [5];
    logic [7:0] closers [4];
    int         sent;
    int         span;
    int         ws;
    clk                  = 1'b0;
    rst_n                = 1'b0;
    in_chan.valid        = 1'b0;
    in_chan.text_byte    = 8'h00;
    in_chan.end_of_text  = 1'b0;
    out_chan.ready       = 1'b0;
    item_row             = NO_ROW;
    openers = '{"=", "\"", "'", "(", "["};
    closers = '{")", "]", "\"", "'"};

    // Hold reset, then release it at a rising edge.
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table, under the first idling pattern.
    for (int r = 0; r < DIR_ROWS; r++)
      send_item(directed_rows[r].b, directed_rows[r].last, r);

    // Random strings: sender idles lightly, then the receiver, then neither.
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 21 : (ph == 1) ? 85 : 0;
      recv_idle_pct = (ph == 0) ? 85 : (ph == 1) ? 21 : 0;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        // Mostly short strings, now and then a long one.
        span = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 10);
        text_q.delete();
        while (text_q.size() < span) begin
          case ($urandom_range(0, 15))
            0: begin
              // Whole drive prefix.
              text_q.insert(text_q.size(), random_letter());
              text_q.insert(text_q.size(), ":");
              text_q.insert(text_q.size(), $urandom_range(0, 1) ? "/" : "\\");
            end
            1:       text_q.insert(text_q.size(), "/");
            2:       text_q.insert(text_q.size(), "\\");
            3:       text_q.insert(text_q.size(), ":");
            4:       text_q.insert(text_q.size(), openers[$urandom_range(0, 4)]);
            5:       text_q.insert(text_q.size(), closers[$urandom_range(0, 3)]);
            6: begin
              // C-locale whitespace: tab through carriage return, or space.
              ws = $urandom_range(9, 14);
              text_q.insert(text_q.size(), ws == 14 ? 8'h20 : 8'(ws));
            end
            7, 8:    text_q.insert(text_q.size(), 8'($urandom_range(0, 255)));
            default: text_q.insert(text_q.size(), random_letter());
          endcase
        end
        foreach (text_q[i])
          send_item(text_q[i], i == text_q.size() - 1, NO_ROW);
        sent += text_q.size();
      end
    end
    in_chan.valid <= 1'b0;

    // Drain what is still expected, then watch for stray results.
    do
      @(posedge clk);
    while (awaited_out.size() != 0);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (mismatches == 0)
      $display("absolute_path_redactor regression: pass");
    else
      $display("absolute_path_redactor regression: fail");
    $finish;
  end

  // Stop a hung run.
  initial begin
    #RUN_LIMIT;
    $display("absolute_path_redactor regression: fail");
    $finish;
  end

endmodule
